>>> rtl/skcw_pkg.sv
`timescale 1ns / 1ps

package skcw_pkg;

  localparam int MAX_KEYWORDS = 16;
  localparam int KW_W = 4;
  localparam int KC_W = 5;
  localparam int QUEUE_DEPTH = 256;
  localparam int QADDR_W = 8;
  localparam int OCC_W = 9;
  localparam int POS_W = 16;
  localparam int CNT_W = 9;
  localparam int LEN_W = 17;
  localparam int ENTRY_W = POS_W + KW_W;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 56;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // take the request on the slave side
    logic pop;       // drop the queue front
    logic evaluate;  // compare the current window with the best one
    logic finish;    // load the result register and clear on end of text
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic kw_push;   // accepted request is a keyword that will be queued
    logic pop_ok;    // front keyword still occurs later in the queue
    logic out_free;  // result register can take a new result
  } dp_status_t;

endpackage

>>> rtl/shortest_keyword_cover_window.sv
`timescale 1ns / 1ps

// Shortest keyword-cover window over a token stream.
//
// Slave side: one request per token. s_tuser carries is_keyword, s_tdata[3:0]
// the keyword index and s_tlast marks the final token of a text. Master side:
// one result per token with the best covering window seen so far in the text.
// Configuration: cfg_wr_en writes the number of keywords to cover and also
// clears the stream state; write it only while no request is in flight.
//
// Sequence: a plain token, an out-of-set keyword or an overflowed token goes
// from idle straight to the done state, where its result enters the result
// register once that register is free. A keyword token first reads and checks
// the queue front, repeating both for each entry popped from the front; each pop
// is a read of the position queue RAM and a check of the front keyword's count.
// Every entry is popped at most once, so pops per keyword average at most one.
// Reset loads a keyword count of 1 and clears counts, queue, position, best
// window and the overflow flag; the same clear follows the result of the token
// marked last. The result register lets the block accept the next token while
// an earlier result waits; a stalled master side stops it only once a second
// result is ready.

module shortest_keyword_cover_window (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [skcw_pkg::KC_W-1:0]           cfg_wr_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [skcw_pkg::IN_DATA_W-1:0]      s_tdata,   // [3:0] keyword_id, rest zero
  input  logic                                s_tuser,   // [0] is_keyword
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] found, [16:1] best_start, [32:17] best_end, [49:33] best_length,
  // [50] improved, [51] overflow, rest zero
  output logic [skcw_pkg::OUT_DATA_W-1:0]     m_tdata
);

  skcw_pkg::dp_cmd_t    cmd;
  skcw_pkg::dp_status_t status;

  skcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  skcw_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .is_keyword  (s_tuser),
    .keyword_id  (s_tdata[skcw_pkg::KW_W-1:0]),
    .last        (s_tlast),
    .cmd         (cmd),
    .status      (status),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

>>> rtl/skcw_ctrl.sv
`timescale 1ns / 1ps

module skcw_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  skcw_pkg::dp_status_t  status,
  output skcw_pkg::dp_cmd_t     cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = status.kw_push ? S_READ : S_DONE;
        end
      end
      // The queue front is read in this cycle; its data is ready in the next.
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.pop_ok) begin
          cmd.pop = 1'b1;
          state_next = S_READ;
        end else begin
          cmd.evaluate = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/skcw_datapath.sv
`timescale 1ns / 1ps

module skcw_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [skcw_pkg::KC_W-1:0]             cfg_wr_data,
  input  logic                                  is_keyword,
  input  logic [skcw_pkg::KW_W-1:0]             keyword_id,
  input  logic                                  last,
  input  skcw_pkg::dp_cmd_t                     cmd,
  output skcw_pkg::dp_status_t                  status,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [skcw_pkg::OUT_DATA_W-1:0]       m_tdata
);

  localparam int POS_CNT_W = skcw_pkg::POS_W + 1;

  logic [skcw_pkg::KC_W-1:0]    kc;
  logic [skcw_pkg::KC_W-1:0]    kc_eff;
  logic [skcw_pkg::CNT_W-1:0]   counts [skcw_pkg::MAX_KEYWORDS];
  logic [skcw_pkg::ENTRY_W-1:0] queue_mem [skcw_pkg::QUEUE_DEPTH];
  logic [skcw_pkg::ENTRY_W-1:0] rd_entry;
  logic [skcw_pkg::QADDR_W-1:0] head;
  logic [skcw_pkg::QADDR_W-1:0] tail;
  logic [skcw_pkg::OCC_W-1:0]   occ;
  logic [skcw_pkg::KC_W-1:0]    distinct;
  logic [POS_CNT_W-1:0]         position;
  logic [skcw_pkg::POS_W-1:0]   cur_pos;
  logic                         found;
  logic [skcw_pkg::POS_W-1:0]   best_start;
  logic [skcw_pkg::POS_W-1:0]   best_end;
  logic [skcw_pkg::LEN_W-1:0]   best_len;
  logic                         improved;
  logic                         ovf_flag;
  logic                         last_tok;

  logic                         kw_valid;
  logic                         ovf_now;
  logic [skcw_pkg::KW_W-1:0]    rd_kw;
  logic [skcw_pkg::POS_W-1:0]   rd_pos;
  logic [skcw_pkg::KW_W-1:0]    cnt_addr;
  logic [skcw_pkg::CNT_W-1:0]   cnt_rd;
  logic [skcw_pkg::LEN_W-1:0]   win_len;
  logic                         covers;
  logic                         clear_stream;

  // Out-of-range keyword counts saturate to the supported range.
  always_comb begin
    if (kc == '0) begin
      kc_eff = skcw_pkg::KC_W'(1);
    end else if (kc > skcw_pkg::KC_W'(skcw_pkg::MAX_KEYWORDS)) begin
      kc_eff = skcw_pkg::KC_W'(skcw_pkg::MAX_KEYWORDS);
    end else begin
      kc_eff = kc;
    end
  end

  assign kw_valid = is_keyword && ({1'b0, keyword_id} < kc_eff);
  assign ovf_now  = position[skcw_pkg::POS_W] || (kw_valid && occ[skcw_pkg::OCC_W-1]);
  assign tail     = head + occ[skcw_pkg::QADDR_W-1:0];
  assign rd_kw    = rd_entry[skcw_pkg::ENTRY_W-1:skcw_pkg::POS_W];
  assign rd_pos   = rd_entry[skcw_pkg::POS_W-1:0];

  // One count port: the new keyword while accepting, otherwise the front keyword.
  assign cnt_addr = cmd.accept ? keyword_id : rd_kw;
  assign cnt_rd   = counts[cnt_addr];

  assign win_len = {1'b0, cur_pos} - {1'b0, rd_pos} + skcw_pkg::LEN_W'(1);
  assign covers  = (distinct >= kc_eff) && (occ != '0);

  assign status.kw_push  = kw_valid && !ovf_now;
  assign status.pop_ok   = (occ != '0) && (cnt_rd > skcw_pkg::CNT_W'(1));
  assign status.out_free = !m_tvalid || m_tready;

  assign clear_stream = cfg_wr_en || (cmd.finish && last_tok);

  always_ff @(posedge clk) begin
    if (cmd.accept && status.kw_push) begin
      queue_mem[tail] <= {keyword_id, position[skcw_pkg::POS_W-1:0]};
    end
    rd_entry <= queue_mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kc <= skcw_pkg::KC_W'(1);
    end else if (cfg_wr_en) begin
      kc <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_stream) begin
      for (int i = 0; i < skcw_pkg::MAX_KEYWORDS; i++) begin
        counts[i] <= '0;
      end
      head       <= '0;
      occ        <= '0;
      distinct   <= '0;
      position   <= '0;
      found      <= 1'b0;
      best_start <= '0;
      best_end   <= '0;
      best_len   <= '0;
      ovf_flag   <= 1'b0;
    end else if (cmd.accept) begin
      if (ovf_now) begin
        ovf_flag <= 1'b1;
      end else begin
        position <= position + POS_CNT_W'(1);
        if (kw_valid) begin
          occ              <= occ + skcw_pkg::OCC_W'(1);
          counts[cnt_addr] <= cnt_rd + skcw_pkg::CNT_W'(1);
          if (cnt_rd == '0) begin
            distinct <= distinct + skcw_pkg::KC_W'(1);
          end
        end
      end
    end else if (cmd.pop) begin
      counts[cnt_addr] <= cnt_rd - skcw_pkg::CNT_W'(1);
      head             <= head + skcw_pkg::QADDR_W'(1);
      occ              <= occ - skcw_pkg::OCC_W'(1);
    end else if (cmd.evaluate) begin
      if (covers && (!found || win_len < best_len)) begin
        found      <= 1'b1;
        best_start <= rd_pos;
        best_end   <= cur_pos;
        best_len   <= win_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_pos  <= position[skcw_pkg::POS_W-1:0];
      last_tok <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      improved <= 1'b0;
    end else if (cmd.accept) begin
      improved <= 1'b0;
    end else if (cmd.evaluate && covers && (!found || win_len < best_len)) begin
      improved <= 1'b1;
    end
  end

  // Result register: holds one result while the next request is worked on.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= {4'b0000, ovf_flag, improved, best_len, best_end, best_start, found};
    end
  end

endmodule

>>> tb/tb_shortest_keyword_cover_window.sv
`timescale 1ns / 1ps

// Self-checking bench for the shortest keyword-cover window block.
//
// An initial block fills a queue of pending token requests. A driver process
// presents them on the slave side, and a monitor checks every result on the
// master side against a software copy of the window tracker. The tracker is
// updated at the clock edge where a request is taken, so the expected result
// of each token is queued in acceptance order. Both sides insert random idle
// cycles. One phase also holds the master side off for a long stretch, which
// makes the block fill up and stall its slave side.
module tb_shortest_keyword_cover_window;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int REPORT_LIMIT = 10;
  localparam int POS_SPACE = 1 << skcw_pkg::POS_W;

  // One token request as it goes into the block.
  typedef struct packed {
    logic                      is_kw;
    logic [skcw_pkg::KW_W-1:0] id;
    logic                      last;
  } token_t;

  // One result as it comes out of the block.
  typedef struct packed {
    logic                       found;
    logic [skcw_pkg::POS_W-1:0] first_pos;
    logic [skcw_pkg::POS_W-1:0] last_pos;
    logic [skcw_pkg::LEN_W-1:0] span;
    logic                       improved;
    logic                       overflow;
  } window_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_wr_en = 1'b0;
  logic [skcw_pkg::KC_W-1:0]       cfg_wr_data = '0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [skcw_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                            s_tuser = 1'b0;
  logic                            s_tlast = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [skcw_pkg::OUT_DATA_W-1:0] m_tdata;

  shortest_keyword_cover_window u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  always #5 clk = ~clk;

  // Requests waiting to be driven and results waiting to be seen.
  token_t  pending_tokens[$];
  window_t expected_windows[$];

  // Handshake flags sampled at the rising edge and read by the falling-edge
  // processes, so the driver and the receiver know what was taken.
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;

  // When quiet_mode is set neither side idles, which gives back-to-back traffic.
  logic quiet_mode = 1'b0;
  logic long_hold_req = 1'b0;
  logic long_hold_started = 1'b0;
  int   hold_left = 0;

  int send_gap = 0;
  int recv_wait = 0;
  int cycle_count = 0;
  int mismatch_cnt = 0;

  // Copy of the block's state, kept by the monitor.
  logic [skcw_pkg::KC_W-1:0]  kc_reg;
  int unsigned                kw_tally[skcw_pkg::MAX_KEYWORDS];
  logic [skcw_pkg::POS_W-1:0] q_pos[skcw_pkg::QUEUE_DEPTH];
  logic [skcw_pkg::KW_W-1:0]  q_kw[skcw_pkg::QUEUE_DEPTH];
  int unsigned                q_head;
  int unsigned                q_fill;
  int unsigned                distinct_cnt;
  int unsigned                next_pos;
  logic                       best_found;
  int unsigned                best_first;
  int unsigned                best_last;
  int unsigned                best_span;
  logic                       ovf_flag;

  function automatic int idle_draw();
    return quiet_mode ? 0 : $urandom_range(0, 10);
  endfunction

  // Clears everything that belongs to one text. Queue entries are left as
  // they are, since no entry is read before it has been written again.
  function automatic void clear_text();
    for (int k = 0; k < skcw_pkg::MAX_KEYWORDS; k++) kw_tally[k] = 0;
    q_head = 0;
    q_fill = 0;
    distinct_cnt = 0;
    next_pos = 0;
    best_found = 1'b0;
    best_first = 0;
    best_last = 0;
    best_span = 0;
    ovf_flag = 1'b0;
  endfunction

  // Advances the tracker by one token and returns the result it produces.
  function automatic window_t cover_step(token_t tok);
    int unsigned eff;
    int unsigned pos;
    int unsigned slot_idx;
    int unsigned front;
    int unsigned len;
    logic        kw_ok;
    logic        improved;
    window_t     w;
    // A count of zero behaves as one; counts above the table size saturate.
    if (kc_reg == 0) begin
      eff = 1;
    end else if (kc_reg > skcw_pkg::MAX_KEYWORDS) begin
      eff = skcw_pkg::MAX_KEYWORDS;
    end else begin
      eff = kc_reg;
    end
    // An index outside the configured keyword set counts as a plain word.
    kw_ok = tok.is_kw && (tok.id < eff);
    improved = 1'b0;
    // A token past the last position, or a keyword that finds the queue
    // full, is dropped and only raises the sticky overflow flag.
    if (next_pos >= POS_SPACE || (kw_ok && q_fill >= skcw_pkg::QUEUE_DEPTH)) begin
      ovf_flag = 1'b1;
    end else begin
      pos = next_pos;
      next_pos++;
      if (kw_ok) begin
        slot_idx = (q_head + q_fill) % skcw_pkg::QUEUE_DEPTH;
        q_pos[slot_idx] = pos[skcw_pkg::POS_W-1:0];
        q_kw[slot_idx] = tok.id;
        q_fill++;
        if (kw_tally[tok.id] == 0) distinct_cnt++;
        kw_tally[tok.id]++;
        // The front entry is redundant while its keyword occurs again later.
        while (q_fill > 0 && kw_tally[q_kw[q_head]] > 1) begin
          kw_tally[q_kw[q_head]]--;
          q_head = (q_head + 1) % skcw_pkg::QUEUE_DEPTH;
          q_fill--;
        end
        if (distinct_cnt >= eff && q_fill > 0) begin
          front = q_pos[q_head];
          len = pos - front + 1;
          // Only a strictly shorter window replaces the best, so ties keep
          // the earliest one.
          if (!best_found || len < best_span) begin
            best_found = 1'b1;
            best_first = front;
            best_last = pos;
            best_span = len;
            improved = 1'b1;
          end
        end
      end
    end
    w.found = best_found;
    w.first_pos = best_first[skcw_pkg::POS_W-1:0];
    w.last_pos = best_last[skcw_pkg::POS_W-1:0];
    w.span = best_span[skcw_pkg::LEN_W-1:0];
    w.improved = improved;
    w.overflow = ovf_flag;
    if (tok.last) clear_text();
    return w;
  endfunction

  // Monitor: tracks configuration writes and accepted requests, and checks
  // each result against the oldest expectation.
  always @(posedge clk) begin : monitor
    token_t  tok;
    window_t pred;
    window_t want;
    window_t got;
    logic [skcw_pkg::OUT_DATA_W-1:52] pad;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_shortest_keyword_cover_window NOT OK");
      $finish;
    end else begin
      in_taken <= !rst && s_tvalid && s_tready;
      out_taken <= !rst && m_tvalid && m_tready;
      if (rst) begin
        kc_reg = skcw_pkg::KC_W'(1);
        clear_text();
      end else begin
        // A register write also clears the text state.
        if (cfg_wr_en) begin
          kc_reg = cfg_wr_data;
          clear_text();
        end
        if (s_tvalid && s_tready) begin
          tok.is_kw = s_tuser;
          tok.id = s_tdata[skcw_pkg::KW_W-1:0];
          tok.last = s_tlast;
          pred = cover_step(tok);
          expected_windows.insert(expected_windows.size(), pred);
        end
        if (m_tvalid && m_tready) begin
          got.found = m_tdata[0];
          got.first_pos = m_tdata[16:1];
          got.last_pos = m_tdata[32:17];
          got.span = m_tdata[49:33];
          got.improved = m_tdata[50];
          got.overflow = m_tdata[51];
          pad = m_tdata[skcw_pkg::OUT_DATA_W-1:52];
          if (expected_windows.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_LIMIT)
              $display("cycle %0d: result with no request outstanding: %h",
                       cycle_count, m_tdata);
          end else begin
            want = expected_windows[0];
            expected_windows.delete(0);
            if (got != want || pad != '0) begin
              mismatch_cnt++;
              if (mismatch_cnt <= REPORT_LIMIT) begin
                $display("cycle %0d: expected found=%0d start=%0d end=%0d len=%0d",
                         cycle_count, want.found, want.first_pos, want.last_pos,
                         want.span);
                $display("  expected impr=%0d ovf=%0d", want.improved, want.overflow);
                $display("  got found=%0d start=%0d end=%0d len=%0d",
                         got.found, got.first_pos, got.last_pos, got.span);
                $display("  got impr=%0d ovf=%0d pad=%h", got.improved, got.overflow,
                         pad);
              end
            end
          end
        end
      end
    end
  end

  // Long hold-off of the master side, started once on request.
  always @(posedge clk) begin : hold_counter
    if (rst) begin
      hold_left <= 0;
    end else if (long_hold_req && !long_hold_started) begin
      hold_left <= LONG_HOLD_CYCLES;
      long_hold_started <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Driver: a request stays on the bus until it is taken, then the next one
  // follows after a random gap.
  always @(negedge clk) begin : driver
    token_t tok;
    logic   waiting;
    if (!rst) begin
      waiting = s_tvalid && !in_taken;
      if (!waiting) begin
        if (send_gap > 0 || pending_tokens.size() == 0) begin
          if (send_gap > 0) send_gap--;
          s_tvalid <= 1'b0;
        end else begin
          tok = pending_tokens[0];
          pending_tokens.delete(0);
          s_tvalid <= 1'b1;
          s_tdata <= {{(skcw_pkg::IN_DATA_W-skcw_pkg::KW_W){1'b0}}, tok.id};
          s_tuser <= tok.is_kw;
          s_tlast <= tok.last;
          send_gap = idle_draw();
        end
      end
    end
  end

  // Receiver: after each result it stalls for a random number of cycles.
  always @(negedge clk) begin : receiver
    if (!rst) begin
      if (out_taken) begin
        recv_wait = idle_draw();
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      m_tready <= (recv_wait == 0) && (hold_left == 0);
    end
  end

  task automatic add_token(input logic kw, input int id, input logic last);
    token_t tok;
    tok.is_kw = kw;
    tok.id = id[skcw_pkg::KW_W-1:0];
    tok.last = last;
    pending_tokens.insert(pending_tokens.size(), tok);
  endtask

  // Waits until every request has been taken and every result has arrived.
  task automatic drain();
    while (pending_tokens.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the keyword count while the block is idle and returns at a
  // rising edge, so the caller can queue requests safely.
  task automatic write_count(input int value);
    drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value[skcw_pkg::KC_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Random texts: mostly keywords inside the configured set, with plain
  // words and out-of-set indexes mixed in. The phase may stop in the middle
  // of a text, which the next register write then clears.
  task automatic random_texts(input int value, input int target, input logic quiet);
    int eff;
    int made;
    int len;
    int r;
    int id;
    logic kw;
    write_count(value);
    quiet_mode = quiet;
    eff = (value == 0) ? 1 :
          ((value > skcw_pkg::MAX_KEYWORDS) ? skcw_pkg::MAX_KEYWORDS : value);
    made = 0;
    while (made < target) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
      for (int i = 0; i < len && made < target; i++) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          kw = 1'b1;
          id = $urandom_range(0, eff - 1);
        end else if (r < 88) begin
          kw = 1'b0;
          id = $urandom_range(0, 15);
        end else begin
          kw = 1'b1;
          id = $urandom_range(0, 15);
        end
        add_token(kw, id, i == len - 1);
        made++;
      end
    end
  endtask

  initial begin : stimulus
    int counts[8];
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);

    // Reset count of one: any keyword 0 is a window of length one, and an
    // index of 1 is out of the set.
    add_token(1'b1, 0, 1'b0);
    add_token(1'b1, 1, 1'b0);
    add_token(1'b0, 0, 1'b1);

    // Three keywords: a repeated front keyword is popped, an out-of-set
    // index and a plain word do not enter the queue, and later, longer
    // windows do not replace the first one.
    write_count(3);
    add_token(1'b0, 0, 1'b0);
    add_token(1'b1, 0, 1'b0);
    add_token(1'b1, 1, 1'b0);
    add_token(1'b1, 0, 1'b0);
    add_token(1'b1, 2, 1'b0);
    add_token(1'b1, 15, 1'b0);
    add_token(1'b1, 1, 1'b0);
    add_token(1'b1, 0, 1'b1);

    // All sixteen keywords, highest index first.
    write_count(16);
    for (int k = 15; k >= 0; k--) add_token(1'b1, k, k == 0);

    // Random phases over several counts, including zero and values above the
    // table size. The second one also holds the master side off for a long
    // stretch so that the block backs up into its slave side.
    counts = '{1, 0, 16, 17, 31, 2, 5, 0};
    counts[7] = $urandom_range(1, 16);
    for (int p = 0; p < 8; p++) begin
      random_texts(counts[p], 70, p == 3 || p == 6);
      if (p == 1) begin
        @(negedge clk);
        long_hold_req = 1'b1;
      end
    end

    // Queue full: keyword 0 stays at the front while keyword 1 piles up
    // behind it until all entries are used. Further keywords are dropped, a
    // plain word still advances, and the overflow flag sticks to the end.
    write_count(2);
    quiet_mode = 1'b0;
    add_token(1'b1, 0, 1'b0);
    for (int i = 0; i < skcw_pkg::QUEUE_DEPTH - 1; i++) add_token(1'b1, 1, 1'b0);
    add_token(1'b1, 1, 1'b0);
    add_token(1'b0, 9, 1'b0);
    add_token(1'b1, 0, 1'b0);
    add_token(1'b0, 6, 1'b1);
    add_token(1'b1, 0, 1'b0);
    add_token(1'b1, 1, 1'b1);

    // A last short random phase at the top of the register range.
    random_texts(31, 40, 1'b0);
    drain();
    repeat (20) @(posedge clk);

    if (mismatch_cnt == 0 && expected_windows.size() == 0) begin
      $display("tb_shortest_keyword_cover_window OK");
    end else begin
      if (expected_windows.size() != 0)
        $display("%0d results never arrived", expected_windows.size());
      $display("tb_shortest_keyword_cover_window NOT OK");
    end
    $finish;
  end

endmodule
